/* rtl/core/qp2p_pkg.sv */
// ----------------------------------------------------------------------------
// qp2p_pkg
// Types and constants shared by the quaternion pose to projection core.
// ----------------------------------------------------------------------------
package qp2p_pkg;

  localparam int QuatW  = 16;
  localparam int TransW = 32;
  localparam int RotW   = 16;
  localparam int NumEnt = 9;
  localparam int ProdW  = 32;
  localparam int NumW   = 35;  // signed numerator, off-diagonal terms doubled
  localparam int MagW   = 34;
  localparam int N2W    = 33;
  localparam int DenW   = N2W + 1;
  localparam int QuoW   = 15;  // quotient never exceeds 16384
  localparam int RemW   = MagW + QuoW + 1;

  localparam logic signed [RotW-1:0] RotOne = 16'sd16384;
  localparam logic signed [RotW-1:0] RotMin = -16'sd16384;

  typedef struct packed {
    logic signed [QuatW-1:0]  quat_w;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [TransW-1:0] trans_x;
    logic signed [TransW-1:0] trans_y;
    logic signed [TransW-1:0] trans_z;
  } pose_in_t;

  typedef struct packed {
    logic signed [RotW-1:0]   rot_00;
    logic signed [RotW-1:0]   rot_01;
    logic signed [RotW-1:0]   rot_02;
    logic signed [RotW-1:0]   rot_10;
    logic signed [RotW-1:0]   rot_11;
    logic signed [RotW-1:0]   rot_12;
    logic signed [RotW-1:0]   rot_20;
    logic signed [RotW-1:0]   rot_21;
    logic signed [RotW-1:0]   rot_22;
    logic signed [TransW-1:0] col_x;
    logic signed [TransW-1:0] col_y;
    logic signed [TransW-1:0] col_z;
  } proj_out_t;

  // Divider pipeline payload, nine lanes sharing one denominator
  typedef struct packed {
    logic [NumEnt-1:0][RemW-1:0] rem;
    logic [DenW-1:0]             den;
    logic [NumEnt-1:0]           neg;
    logic [NumEnt-1:0][QuoW-1:0] quo;
    logic                        zero;
    logic [2:0][TransW-1:0]      trans;
  } div_beat_t;

endpackage

/* rtl/core/qp2p_front.sv */
// ----------------------------------------------------------------------------
// qp2p_front
// Three stages: quaternion products, numerators and norm, rounded dividends.
// ----------------------------------------------------------------------------
module qp2p_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  qp2p_pkg::pose_in_t   data_i,
  output logic                 valid_o,
  output qp2p_pkg::div_beat_t  data_o
);

  // stage 1: products
  logic signed [qp2p_pkg::ProdW-1:0] ww_q, xx_q, yy_q, zz_q;
  logic signed [qp2p_pkg::ProdW-1:0] xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic [2:0][qp2p_pkg::TransW-1:0]  tr1_q;
  logic                              v1_q;

  // stage 2: numerators and squared norm
  logic signed [qp2p_pkg::NumEnt-1:0][qp2p_pkg::NumW-1:0] num_q, num_d;
  logic [qp2p_pkg::N2W-1:0]          n2_q, n2_d;
  logic [2:0][qp2p_pkg::TransW-1:0]  tr2_q;
  logic                              v2_q;

  // stage 3
  qp2p_pkg::div_beat_t               out_q, out_d;
  logic                              v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q  <= data_i.quat_w * data_i.quat_w;
      xx_q  <= data_i.quat_x * data_i.quat_x;
      yy_q  <= data_i.quat_y * data_i.quat_y;
      zz_q  <= data_i.quat_z * data_i.quat_z;
      xy_q  <= data_i.quat_x * data_i.quat_y;
      xz_q  <= data_i.quat_x * data_i.quat_z;
      yz_q  <= data_i.quat_y * data_i.quat_z;
      wx_q  <= data_i.quat_w * data_i.quat_x;
      wy_q  <= data_i.quat_w * data_i.quat_y;
      wz_q  <= data_i.quat_w * data_i.quat_z;
      tr1_q <= {data_i.trans_z, data_i.trans_y, data_i.trans_x};
      num_q <= num_d;
      n2_q  <= n2_d;
      tr2_q <= tr1_q;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    n2_d = qp2p_pkg::N2W'($unsigned(ww_q)) + qp2p_pkg::N2W'($unsigned(xx_q))
         + qp2p_pkg::N2W'($unsigned(yy_q)) + qp2p_pkg::N2W'($unsigned(zz_q));
    num_d[0] = qp2p_pkg::NumW'(ww_q) + qp2p_pkg::NumW'(xx_q)
             - qp2p_pkg::NumW'(yy_q) - qp2p_pkg::NumW'(zz_q);
    num_d[4] = qp2p_pkg::NumW'(ww_q) - qp2p_pkg::NumW'(xx_q)
             + qp2p_pkg::NumW'(yy_q) - qp2p_pkg::NumW'(zz_q);
    num_d[8] = qp2p_pkg::NumW'(ww_q) - qp2p_pkg::NumW'(xx_q)
             - qp2p_pkg::NumW'(yy_q) + qp2p_pkg::NumW'(zz_q);
    num_d[1] = (qp2p_pkg::NumW'(xy_q) - qp2p_pkg::NumW'(wz_q)) <<< 1;
    num_d[3] = (qp2p_pkg::NumW'(xy_q) + qp2p_pkg::NumW'(wz_q)) <<< 1;
    num_d[2] = (qp2p_pkg::NumW'(xz_q) + qp2p_pkg::NumW'(wy_q)) <<< 1;
    num_d[6] = (qp2p_pkg::NumW'(xz_q) - qp2p_pkg::NumW'(wy_q)) <<< 1;
    num_d[5] = (qp2p_pkg::NumW'(yz_q) - qp2p_pkg::NumW'(wx_q)) <<< 1;
    num_d[7] = (qp2p_pkg::NumW'(yz_q) + qp2p_pkg::NumW'(wx_q)) <<< 1;
  end

  // dividend = |num| * 2^15 + n2 over divisor 2*n2 gives round half away
  always_comb begin
    logic [qp2p_pkg::NumW-1:0] mag;
    out_d       = '0;
    out_d.den   = {n2_q, 1'b0};
    out_d.zero  = (n2_q == '0);
    out_d.trans = tr2_q;
    for (int i = 0; i < qp2p_pkg::NumEnt; i++) begin
      out_d.neg[i] = num_q[i][qp2p_pkg::NumW-1];
      mag = out_d.neg[i] ? -num_q[i] : num_q[i];
      out_d.rem[i] = qp2p_pkg::RemW'({mag[qp2p_pkg::MagW-1:0], {qp2p_pkg::QuoW{1'b0}}})
                   + qp2p_pkg::RemW'(n2_q);
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

/* rtl/core/qp2p_div_step.sv */
// ----------------------------------------------------------------------------
// qp2p_div_step
// One restoring division step on all nine lanes, registered.
// ----------------------------------------------------------------------------
module qp2p_div_step #(
  parameter int Bit = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  qp2p_pkg::div_beat_t  data_i,
  output logic                 valid_o,
  output qp2p_pkg::div_beat_t  data_o
);

  qp2p_pkg::div_beat_t data_d, data_q;
  logic                valid_q;
  logic [qp2p_pkg::RemW-1:0] trial;

  assign trial = qp2p_pkg::RemW'(data_i.den) << Bit;

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < qp2p_pkg::NumEnt; i++) begin
      if (data_i.rem[i] >= trial) begin
        data_d.rem[i]      = data_i.rem[i] - trial;
        data_d.quo[i][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/quaternion_pose_to_projection_core.sv */
// ----------------------------------------------------------------------------
// quaternion_pose_to_projection_core
// Quaternion pose to 3x4 projection matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one pose beat: quaternion
// w,x,y,z (Q3.12) and translation (Q16.16). Output channel
// out_valid_o/out_ready_i carries the nine Q1.14 rotation entries and the
// translation column, one result beat per pose, in order.
// From acceptance to out_valid_o a pose passes three front stages
// (products, norm and numerators, dividends), fifteen divider stages that
// each settle one quotient bit for all nine entries, and the output
// register. Throughput is one pose per cycle while the output is not stalled.
// A zero quaternion gives the identity rotation.
// Reset clears all valid bits; the pipeline is then empty and ready.
// When the receiver holds out_ready_i low with a result waiting, the whole
// pipeline freezes and in_ready_o drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
module quaternion_pose_to_projection_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  qp2p_pkg::pose_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qp2p_pkg::proj_out_t  out_data_o
);

  localparam int Steps = qp2p_pkg::QuoW;

  logic                en;
  logic [Steps:0]      dv;
  qp2p_pkg::div_beat_t dd [Steps+1];

  qp2p_pkg::proj_out_t out_q, out_d;
  logic                out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  qp2p_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (dv[0]),
    .data_o  (dd[0])
  );

  for (genvar g = 0; g < Steps; g++) begin : g_div
    qp2p_div_step #(
      .Bit (Steps - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .data_i  (dd[g]),
      .valid_o (dv[g+1]),
      .data_o  (dd[g+1])
    );
  end

  logic [qp2p_pkg::NumEnt-1:0][qp2p_pkg::RotW-1:0] rot;

  always_comb begin
    logic signed [qp2p_pkg::RotW-1:0] mag;
    logic signed [qp2p_pkg::RotW-1:0] val;
    for (int i = 0; i < qp2p_pkg::NumEnt; i++) begin
      mag = $signed({1'b0, dd[Steps].quo[i]});
      val = dd[Steps].neg[i] ? -mag : mag;
      if (val > qp2p_pkg::RotOne) val = qp2p_pkg::RotOne;
      if (val < qp2p_pkg::RotMin) val = qp2p_pkg::RotMin;
      if (dd[Steps].zero) begin
        val = ((i % 4) == 0) ? qp2p_pkg::RotOne : '0;
      end
      rot[i] = val;
    end
    out_d.rot_00 = rot[0];
    out_d.rot_01 = rot[1];
    out_d.rot_02 = rot[2];
    out_d.rot_10 = rot[3];
    out_d.rot_11 = rot[4];
    out_d.rot_12 = rot[5];
    out_d.rot_20 = rot[6];
    out_d.rot_21 = rot[7];
    out_d.rot_22 = rot[8];
    out_d.col_x  = dd[Steps].trans[0];
    out_d.col_y  = dd[Steps].trans[1];
    out_d.col_z  = dd[Steps].trans[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[Steps];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // diagonal entries rot_00 and rot_11 stay inside plus or minus one
  a_rot00_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.rot_00 <= qp2p_pkg::RotOne
                     && out_data_o.rot_00 >= qp2p_pkg::RotMin))
    else $error("rot_00 out of range");

  a_rot11_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.rot_11 <= qp2p_pkg::RotOne
                     && out_data_o.rot_11 >= qp2p_pkg::RotMin))
    else $error("rot_11 out of range");

  // zero quaternion leaves the divider as an identity rotation
  a_zero_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dv[Steps] && dd[Steps].zero) |=>
      (out_valid_o && out_data_o.rot_00 == qp2p_pkg::RotOne
       && out_data_o.rot_01 == '0 && out_data_o.rot_22 == qp2p_pkg::RotOne))
    else $error("zero quaternion did not give identity");

  // a frozen pipeline keeps the waiting result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> (out_valid_o && $stable(out_q)))
    else $error("result lost during stall");

endmodule

/* verif/quaternion_pose_to_projection_core_checker.sv */
// ----------------------------------------------------------------------------
// quaternion_pose_to_projection_core_checker
// Watches both channels, predicts each projection beat and compares it.
// ----------------------------------------------------------------------------
module quaternion_pose_to_projection_core_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  qp2p_pkg::pose_in_t   in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  qp2p_pkg::proj_out_t  out_data_i,
  output int                   err_cnt_o,
  output int                   pending_o,
  output int                   result_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  qp2p_pkg::proj_out_t proj_fifo[$];

  // round to nearest, half away from zero; den > 0
  function automatic longint ratio_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [qp2p_pkg::RotW-1:0] clamp_q14(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[qp2p_pkg::RotW-1:0];
  endfunction

  function automatic qp2p_pkg::proj_out_t project_pose(qp2p_pkg::pose_in_t p);
    qp2p_pkg::proj_out_t r;
    longint w, x, y, z, w2, x2, y2, z2, n2;
    w = p.quat_w; x = p.quat_x; y = p.quat_y; z = p.quat_z;
    w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
    n2 = w2 + x2 + y2 + z2;
    if (n2 == 0) begin
      r = '0;
      r.rot_00 = qp2p_pkg::RotOne;
      r.rot_11 = qp2p_pkg::RotOne;
      r.rot_22 = qp2p_pkg::RotOne;
    end else begin
      r.rot_00 = clamp_q14(ratio_round((w2 + x2 - y2 - z2) * 16384, n2));
      r.rot_01 = clamp_q14(ratio_round((x * y - w * z) * 32768, n2));
      r.rot_02 = clamp_q14(ratio_round((x * z + w * y) * 32768, n2));
      r.rot_10 = clamp_q14(ratio_round((x * y + w * z) * 32768, n2));
      r.rot_11 = clamp_q14(ratio_round((w2 - x2 + y2 - z2) * 16384, n2));
      r.rot_12 = clamp_q14(ratio_round((y * z - w * x) * 32768, n2));
      r.rot_20 = clamp_q14(ratio_round((x * z - w * y) * 32768, n2));
      r.rot_21 = clamp_q14(ratio_round((y * z + w * x) * 32768, n2));
      r.rot_22 = clamp_q14(ratio_round((w2 - x2 - y2 + z2) * 16384, n2));
    end
    r.col_x = p.trans_x;
    r.col_y = p.trans_y;
    r.col_z = p.trans_z;
    return r;
  endfunction

  initial begin
    err_cnt_o = 0;
    result_cnt_o = 0;
  end

  assign pending_o = proj_fifo.size();

  always @(posedge clk_i) begin
    qp2p_pkg::proj_out_t exp_beat;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        proj_fifo = {proj_fifo, project_pose(in_data_i)};
      end
      if (out_valid_i && out_ready_i) begin
        result_cnt_o <= result_cnt_o + 1;
        if (proj_fifo.size() == 0) begin
          $display("%0t: unexpected beat, got %h", $time, out_data_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_beat = proj_fifo.pop_front();
          if (exp_beat != out_data_i) begin
            err_cnt_o <= err_cnt_o + 1;
            $display("%0t: rot exp %0d %0d %0d / %0d %0d %0d / %0d %0d %0d", $time,
                     exp_beat.rot_00, exp_beat.rot_01, exp_beat.rot_02,
                     exp_beat.rot_10, exp_beat.rot_11, exp_beat.rot_12,
                     exp_beat.rot_20, exp_beat.rot_21, exp_beat.rot_22);
            $display("%0t: rot got %0d %0d %0d / %0d %0d %0d / %0d %0d %0d", $time,
                     out_data_i.rot_00, out_data_i.rot_01, out_data_i.rot_02,
                     out_data_i.rot_10, out_data_i.rot_11, out_data_i.rot_12,
                     out_data_i.rot_20, out_data_i.rot_21, out_data_i.rot_22);
            $display("%0t: col exp %h %h %h got %h %h %h", $time,
                     exp_beat.col_x, exp_beat.col_y, exp_beat.col_z,
                     out_data_i.col_x, out_data_i.col_y, out_data_i.col_z);
          end
        end
      end
    end
  end

endmodule

/* verif/quaternion_pose_to_projection_core_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_pose_to_projection_core_tb
// Directed corner poses then random poses with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module quaternion_pose_to_projection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRand  = 900;
  localparam int Latency  = 19;
  localparam int CycLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  qp2p_pkg::pose_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  qp2p_pkg::proj_out_t out_data;
  int                  err_cnt, pending, result_cnt;
  int                  cyc = 0;
  logic                stim_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  quaternion_pose_to_projection_core u_dut (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid), .in_ready_o (in_ready), .in_data_i (in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  quaternion_pose_to_projection_core_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid), .in_ready_i (in_ready), .in_data_i (in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .err_cnt_o(err_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_quat_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // one beat: valid high at the falling edge, held until accepted
  task automatic send_pose(qp2p_pkg::pose_in_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    qp2p_pkg::pose_in_t p;
    p = {w, x, y, z, 32'($urandom), 32'($urandom), 32'($urandom)};
    send_pose(p);
  endtask

  // receiver: random stalls, plus one long hold-off early on
  initial begin
    int n;
    @(posedge rst_ni);
    @(negedge clk_i);
    out_ready <= 1'b1;
    repeat (60) @(negedge clk_i);
    out_ready <= 1'b0;
    repeat (200) @(negedge clk_i);
    forever begin
      out_ready <= 1'b1;
      n = gap_len();
      if (n != 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("timeout at cycle %0d", cyc);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // corners: zero quaternion, unit axes, sign extremes, half-rounding
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h1000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h1000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h1000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h1000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0000);
    send_quat(16'h0003, 16'h0001, 16'h0002, 16'hffff);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h7fff, 16'h8000, 16'h0001);
    send_pose({16'h0, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
    send_pose({16'h1000, 16'h0, 16'h0, 16'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0});
    for (int i = 0; i < NumRand; i++) begin
      send_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
      n = gap_len();
      if (n != 0) begin
        in_valid <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    $display("Ran %0d poses incl. zero, axis and extreme quaternions; %0d beats checked",
             NumRand + 16, result_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/qp2p_pkg.sv
rtl/core/qp2p_front.sv
rtl/core/qp2p_div_step.sv
rtl/core/quaternion_pose_to_projection_core.sv
verif/quaternion_pose_to_projection_core_checker.sv
verif/quaternion_pose_to_projection_core_tb.sv
